### design/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Types and constants shared by the button press mode LED controller.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CountW-1:0] HoldMax = 8'd255;

  // Reset values of the configuration registers.
  localparam logic [CfgDataW-1:0] LongThreshRst = 8'd30;
  localparam logic [CfgDataW-1:0] ShortThreshRst = 8'd5;
  localparam logic [CfgDataW-1:0] BlinkPeriodRst = 8'd10;
  localparam logic [CfgDataW-1:0] BlinkOnRst = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_THRESHOLD  = 2'd0,
    CFG_SHORT_THRESHOLD = 2'd1,
    CFG_BLINK_PERIOD    = 2'd2,
    CFG_BLINK_ON_TICKS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } press_evt_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_REC   = 2'd2,
    MODE_BLINK = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CfgDataW-1:0] long_threshold;
    logic [CfgDataW-1:0] short_threshold;
    logic [CfgDataW-1:0] blink_period;
    logic [CfgDataW-1:0] blink_on_ticks;
  } cfg_t;

endpackage

### design/bpm_if.sv
// ----------------------------------------------------------------------------
// bpm_in_if / bpm_out_if
// Valid/ready channels carrying button samples and controller results.
// ----------------------------------------------------------------------------
interface bpm_in_if import bpm_pkg::*; ();
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface

interface bpm_out_if import bpm_pkg::*; ();
  logic       valid;
  logic       ready;
  press_evt_e press_event;
  mode_e      mode;
  logic       led_lit;

  modport source (output valid, output press_event, output mode, output led_lit, input ready);
  modport sink (input valid, input press_event, input mode, input led_lit, output ready);
endinterface

### design/button_press_mode_led_controller.sv
// ----------------------------------------------------------------------------
// button_press_mode_led_controller
// Short/long push-button press detector that steers a mode and an LED.
// ----------------------------------------------------------------------------
// Each word on the input channel is one tick carrying the sampled button
// level. For every accepted word the block returns exactly one result word
// on the output channel: the press event seen this tick (none, short, long),
// the mode after the update, and whether the LED is lit.
//
// The press detector and the mode/blink state update in the cycle the input
// word is accepted, and the result is captured in an output register. A
// result therefore appears in the cycle after its input is accepted, and one
// word can be accepted every cycle while the receiver keeps up: the only path
// limiting the rate is the state update feeding the output register.
//
// The input is ready whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result word
// steady and back-pressures the sender without losing state.
//
// Reset (asynchronous, active low) clears the hold logic, sets the mode to
// off, clears the blink counter, empties the output register and loads the
// thresholds and blink timing with their defaults (30, 5, 10 and 5).
// Configuration writes are registered and should only be made while no
// word is in flight.
// ----------------------------------------------------------------------------
module button_press_mode_led_controller import bpm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bpm_in_if.sink              in_i,
  bpm_out_if.source           out_o
);

  cfg_t       cfg_q;
  logic       step;
  press_evt_e evt;
  mode_e      mode;
  logic       led;

  logic       out_valid_q;
  press_evt_e out_evt_q;
  mode_e      out_mode_q;
  logic       out_led_q;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_threshold  <= LongThreshRst;
      cfg_q.short_threshold <= ShortThreshRst;
      cfg_q.blink_period    <= BlinkPeriodRst;
      cfg_q.blink_on_ticks  <= BlinkOnRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LONG_THRESHOLD:  cfg_q.long_threshold  <= cfg_data_i;
        CFG_SHORT_THRESHOLD: cfg_q.short_threshold <= cfg_data_i;
        CFG_BLINK_PERIOD:    cfg_q.blink_period    <= cfg_data_i;
        CFG_BLINK_ON_TICKS:  cfg_q.blink_on_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  bpm_press_det u_press_det (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .pressed_i         (in_i.button_pressed),
    .long_threshold_i  (cfg_q.long_threshold),
    .short_threshold_i (cfg_q.short_threshold),
    .evt_o             (evt)
  );

  bpm_mode_led u_mode_led (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .evt_i            (evt),
    .blink_period_i   (cfg_q.blink_period),
    .blink_on_ticks_i (cfg_q.blink_on_ticks),
    .mode_o           (mode),
    .led_o            (led)
  );

  // Output register: loads on every accepted tick, empties when drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_evt_q  <= evt;
      out_mode_q <= mode;
      out_led_q  <= led;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.press_event = out_evt_q;
  assign out_o.mode        = out_mode_q;
  assign out_o.led_lit     = out_led_q;

endmodule

### design/bpm_press_det.sv
// ----------------------------------------------------------------------------
// bpm_press_det
// Hold counter that classifies presses as short or long.
// ----------------------------------------------------------------------------
module bpm_press_det import bpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              pressed_i,
  input  logic [CountW-1:0] long_threshold_i,
  input  logic [CountW-1:0] short_threshold_i,
  output press_evt_e        evt_o
);

  logic              holding_q, holding_d;
  logic              armed_q, armed_d;
  logic [CountW-1:0] hold_ticks_q, hold_ticks_d;
  logic [CountW-1:0] seen;

  always_comb begin
    seen         = armed_q ? hold_ticks_q : '0;
    evt_o        = EVT_NONE;
    holding_d    = holding_q;
    armed_d      = armed_q;
    hold_ticks_d = hold_ticks_q;
    if (pressed_i) begin
      if (!holding_q) begin
        holding_d    = 1'b1;
        armed_d      = 1'b1;
        hold_ticks_d = '0;
      end else begin
        if (armed_q && (seen > long_threshold_i)) begin
          evt_o   = EVT_LONG;
          armed_d = 1'b0;
        end
        if (hold_ticks_q != HoldMax) begin
          hold_ticks_d = hold_ticks_q + 1'b1;
        end
      end
    end else begin
      if (holding_q && armed_q && (seen > short_threshold_i)) begin
        evt_o = EVT_SHORT;
      end
      holding_d    = 1'b0;
      armed_d      = 1'b0;
      hold_ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q    <= 1'b0;
      armed_q      <= 1'b0;
      hold_ticks_q <= '0;
    end else if (step_i) begin
      holding_q    <= holding_d;
      armed_q      <= armed_d;
      hold_ticks_q <= hold_ticks_d;
    end
  end

endmodule

### design/bpm_mode_led.sv
// ----------------------------------------------------------------------------
// bpm_mode_led
// Mode register driven by press events, and the blink counter for the LED.
// ----------------------------------------------------------------------------
module bpm_mode_led import bpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  press_evt_e        evt_i,
  input  logic [CountW-1:0] blink_period_i,
  input  logic [CountW-1:0] blink_on_ticks_i,
  output mode_e             mode_o,
  output logic              led_o
);

  mode_e             mode_q, mode_d;
  logic [CountW-1:0] blink_q, blink_d;
  logic [CountW:0]   blink_inc;
  logic              in_on;

  always_comb begin
    mode_d = mode_q;
    case (evt_i)
      EVT_SHORT: begin
        if (mode_q == MODE_IDLE) begin
          mode_d = MODE_REC;
        end else if (mode_q == MODE_REC) begin
          mode_d = MODE_IDLE;
        end
      end
      EVT_LONG: begin
        if (mode_q == MODE_OFF) begin
          mode_d = MODE_IDLE;
        end else if ((mode_q == MODE_IDLE) || (mode_q == MODE_REC)) begin
          mode_d = MODE_OFF;
        end
      end
      default: mode_d = mode_q;
    endcase
  end

  // The counter wraps as soon as the incremented value reaches the period.
  always_comb begin
    blink_inc = {1'b0, blink_q} + 1'b1;
    if (blink_inc >= {1'b0, blink_period_i}) begin
      blink_d = '0;
    end else begin
      blink_d = blink_inc[CountW-1:0];
    end
    in_on = blink_d < blink_on_ticks_i;
  end

  always_comb begin
    case (mode_d)
      MODE_IDLE:  led_o = 1'b1;
      MODE_REC:   led_o = in_on;
      MODE_BLINK: led_o = in_on && blink_d[0];
      default:    led_o = 1'b0;
    endcase
  end

  assign mode_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      blink_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      blink_q <= blink_d;
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the button press mode LED controller.
// ----------------------------------------------------------------------------
// Button samples go into the controller on the input channel. Every accepted
// word is run through a behavioral copy of the press detector, mode register
// and blink counter. Its result, or a pinned row's typed one, is queued, and
// each result word leaving the block is compared with the oldest entry.
// A short directed table comes first. After it, settings change phase by
// phase, and each phase sends random press and release runs of varied length.
// ----------------------------------------------------------------------------
module tb_top;
  import bpm_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    press_evt_e evt;
    mode_e      mode;
    logic       led;
  } indication_t;

  // One row of the directed table. A pinned row carries a result that is
  // obvious from the scenario and is checked as typed. Every other row is
  // checked against the predictor.
  typedef struct packed {
    logic        pressed;
    logic        pinned;
    indication_t want;
  } tick_row_t;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned IdlePct       = 29;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bpm_in_if  in_ch ();
  bpm_out_if out_ch ();

  button_press_mode_led_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predictor state. It mirrors the block: the configuration, whether the
  // button is down, whether the press can still report, the hold length, the
  // mode and the position in the blink cycle.
  cfg_t        ctrl_cfg;
  logic        btn_down;
  logic        press_live;
  logic [7:0]  hold_len;
  mode_e       cur_mode;
  logic [7:0]  blink_phase;

  // Results the block still owes, oldest first.
  indication_t indications_due [$];

  // Expectation that goes with the word currently offered by the sender.
  logic        row_pinned;
  indication_t row_expect;

  // Shared between the stimulus and the two channel drivers.
  logic        no_idle;
  logic        hold_off_start;
  logic        hold_off_done;
  int unsigned stall_left;

  int unsigned fail_count;
  int unsigned ticks_taken;
  int unsigned words_checked;
  int unsigned short_seen;
  int unsigned long_seen;
  int unsigned cycle_count;

  int unsigned phase_len [NumPhases] = '{250, 200, 300, 300, 200, 200, 250, 250};

  // With a long threshold of 1 and a short threshold of 0, a press reports
  // long on its fourth pressed tick, and a two-tick press reports short on
  // release. This keeps every mode transition inside a short table.
  tick_row_t directed_rows [24] = '{
    // Release with nothing held, straight after reset: mode off, LED dark.
    '{1'b0, 1'b1, '{EVT_NONE, MODE_OFF, 1'b0}},
    // First pressed tick only arms the detector.
    '{1'b1, 1'b1, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    // Long press from off turns the controller on; idle keeps the LED lit.
    '{1'b1, 1'b1, '{EVT_LONG, MODE_IDLE, 1'b1}},
    '{1'b1, 1'b1, '{EVT_NONE, MODE_IDLE, 1'b1}},
    // Releasing after a long press reports nothing.
    '{1'b0, 1'b1, '{EVT_NONE, MODE_IDLE, 1'b1}},
    // A one-tick press never exceeds even a zero short threshold.
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b0, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    // Short press: idle to recording.
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b0, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    // Short press: recording back to idle.
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b0, 1'b1, '{EVT_SHORT, MODE_IDLE, 1'b1}},
    // Long press from idle turns the controller off.
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b1, '{EVT_LONG, MODE_OFF, 1'b0}},
    '{1'b0, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    // A short press while off is ignored.
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b1, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b0, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}},
    '{1'b0, 1'b0, '{EVT_NONE, MODE_OFF, 1'b0}}
  };

  always #5 clk_i = ~clk_i;

  // Works out the result word for one tick and advances the predictor state.
  // The hold length seen by the detector is the value before this tick, and
  // a press that has already reported long sees zero from then on.
  function automatic indication_t predict_indication(logic pressed);
    indication_t res;
    logic [7:0]  seen;
    logic [8:0]  nxt;
    logic        in_on;
    res.evt = EVT_NONE;
    seen    = press_live ? hold_len : 8'd0;
    if (pressed) begin
      if (!btn_down) begin
        btn_down   = 1'b1;
        press_live = 1'b1;
        hold_len   = 8'd0;
      end else begin
        if (press_live && seen > ctrl_cfg.long_threshold) begin
          res.evt    = EVT_LONG;
          press_live = 1'b0;
        end
        if (hold_len != HoldMax) begin
          hold_len = hold_len + 8'd1;
        end
      end
    end else begin
      if (btn_down && press_live && seen > ctrl_cfg.short_threshold) begin
        res.evt = EVT_SHORT;
      end
      btn_down   = 1'b0;
      press_live = 1'b0;
      hold_len   = 8'd0;
    end

    case (res.evt)
      EVT_SHORT: begin
        if (cur_mode == MODE_IDLE) begin
          cur_mode = MODE_REC;
        end else if (cur_mode == MODE_REC) begin
          cur_mode = MODE_IDLE;
        end
      end
      EVT_LONG: begin
        if (cur_mode == MODE_OFF) begin
          cur_mode = MODE_IDLE;
        end else if (cur_mode != MODE_BLINK) begin
          cur_mode = MODE_OFF;
        end
      end
      default: begin
      end
    endcase

    // The blink counter steps before the LED is decided. A period of zero or
    // one pins it at zero, and a count beyond a shortened period wraps.
    nxt = {1'b0, blink_phase} + 9'd1;
    if (nxt >= {1'b0, ctrl_cfg.blink_period}) begin
      nxt = 9'd0;
    end
    blink_phase = nxt[7:0];
    in_on       = blink_phase < ctrl_cfg.blink_on_ticks;

    case (cur_mode)
      MODE_IDLE:  res.led = 1'b1;
      MODE_REC:   res.led = in_on;
      MODE_BLINK: res.led = in_on & blink_phase[0];
      default:    res.led = 1'b0;
    endcase
    res.mode = cur_mode;
    return res;
  endfunction

  // Offers one button sample and returns at the falling edge after it was
  // taken. Idle gaps come before the word; valid stays high between words
  // that follow each other without a gap.
  task automatic send_tick(logic pressed, logic pinned, indication_t want);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.button_pressed <= pressed;
    row_pinned = pinned;
    row_expect = want;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every owed result word has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (indications_due.size() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Writes all four registers, one per cycle, while nothing is in flight.
  task automatic load_cfg(cfg_t c);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LONG_THRESHOLD;
    cfg_data_i  <= c.long_threshold;
    @(negedge clk_i);
    cfg_index_i <= CFG_SHORT_THRESHOLD;
    cfg_data_i  <= c.short_threshold;
    @(negedge clk_i);
    cfg_index_i <= CFG_BLINK_PERIOD;
    cfg_data_i  <= c.blink_period;
    @(negedge clk_i);
    cfg_index_i <= CFG_BLINK_ON_TICKS;
    cfg_data_i  <= c.blink_on_ticks;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ctrl_cfg = c;
  endtask

  // Sends press and release runs until n_ticks words have gone in; the last
  // run is cut short at that count. Most presses are sized against the
  // thresholds so that short and long presses both happen; some run long
  // enough to saturate the hold count, and the rest are one-to-few tick
  // bounces.
  task automatic run_presses(int unsigned n_ticks);
    int unsigned sent;
    int unsigned press_len;
    int unsigned rel_len;
    int unsigned pick;
    indication_t none;
    sent = 0;
    none = '{EVT_NONE, MODE_OFF, 1'b0};
    while (sent < n_ticks) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        press_len = $urandom_range(1, int'(ctrl_cfg.short_threshold) + 3);
      end else if (pick <= 5) begin
        press_len = int'(ctrl_cfg.long_threshold) + $urandom_range(0, 4);
      end else if (pick == 6) begin
        press_len = $urandom_range(1, 300);
      end else begin
        press_len = $urandom_range(1, 6);
      end
      rel_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
      if (press_len > n_ticks - sent) begin
        press_len = n_ticks - sent;
      end
      if (rel_len > n_ticks - sent - press_len) begin
        rel_len = n_ticks - sent - press_len;
      end
      repeat (press_len) begin
        send_tick(1'b1, 1'b0, none);
      end
      repeat (rel_len) begin
        send_tick(1'b0, 1'b0, none);
      end
      sent += press_len + rel_len;
    end
  endtask

  // Receiver. It idles at random, never while the stimulus asks for a
  // steady flow, and once it holds off for a long stretch so that the
  // output register stays full and the block stalls its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (hold_off_start && !hold_off_done) begin
      out_ch.ready <= 1'b0;
      stall_left    = HoldOffCycles;
      hold_off_done = 1'b1;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Both channels are watched in one process: an accepted sample is
  // predicted before any result of the same edge is checked, so the
  // comparison holds however short the block's latency is.
  always @(posedge clk_i) begin : watch_channels
    indication_t calc;
    indication_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        calc = predict_indication(in_ch.button_pressed);
        indications_due.push_back(row_pinned ? row_expect : calc);
        ticks_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (indications_due.size() == 0) begin
          $error("result word with no button sample pending");
          fail_count++;
        end else begin
          want = indications_due.pop_front();
          words_checked++;
          if (out_ch.press_event !== want.evt) begin
            $error("press_event: expected %0d, actual %0d", want.evt, out_ch.press_event);
            fail_count++;
          end
          if (out_ch.mode !== want.mode) begin
            $error("mode: expected %0d, actual %0d", want.mode, out_ch.mode);
            fail_count++;
          end
          if (out_ch.led_lit !== want.led) begin
            $error("led_lit: expected %0d, actual %0d", want.led, out_ch.led_lit);
            fail_count++;
          end
          if (out_ch.press_event == EVT_SHORT) begin
            short_seen++;
          end
          if (out_ch.press_event == EVT_LONG) begin
            long_seen++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_LONG_THRESHOLD;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.button_pressed = 1'b0;
    out_ch.ready         = 1'b0;
    row_pinned           = 1'b0;
    row_expect           = '{EVT_NONE, MODE_OFF, 1'b0};
    no_idle              = 1'b0;
    hold_off_start       = 1'b0;
    hold_off_done        = 1'b0;
    stall_left           = 0;
    fail_count           = 0;
    ticks_taken          = 0;
    words_checked        = 0;
    short_seen           = 0;
    long_seen            = 0;
    cycle_count          = 0;

    // Predictor starts from the reset state of the block.
    ctrl_cfg    = '{LongThreshRst, ShortThreshRst, BlinkPeriodRst, BlinkOnRst};
    btn_down    = 1'b0;
    press_live  = 1'b0;
    hold_len    = 8'd0;
    cur_mode    = MODE_OFF;
    blink_phase = 8'd0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: a long threshold of 1, a short threshold of 0 and a blink period of 2.
    load_cfg('{8'd1, 8'd0, 8'd2, 8'd1});
    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].pressed, directed_rows[i].pinned, directed_rows[i].want);
    end
    drain_results();

    // Random part, one setting per phase. The phases visit the reset values,
    // both ends of every register, a long threshold of 255 (no long press,
    // the hold count saturates), blink periods of zero and one, an on time
    // longer than the period, and random settings. Phase one runs with no
    // idling on either side; phase five carries the long receiver hold-off.
    // Every phase ends with the sender paused until all results are in.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: c = '{LongThreshRst, ShortThreshRst, BlinkPeriodRst, BlinkOnRst};
        1: c = '{8'd1, 8'd0, 8'd2, 8'd1};
        2: c = '{8'd254, 8'd254, 8'd255, 8'd255};
        3: c = '{8'd255, 8'd255, 8'd0, 8'd0};
        4: c = '{8'd12, 8'd3, 8'd1, 8'd3};
        5: c = '{8'd8, 8'd2, 8'd7, 8'd200};
        6: c = '{8'($urandom_range(1, 40)), 8'($urandom_range(0, 20)),
                 8'($urandom_range(2, 40)), 8'($urandom_range(1, 40))};
        default: c = '{8'd0, 8'($urandom_range(0, 10)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      endcase
      no_idle        = (p == 1);
      hold_off_start = (p == 5);
      load_cfg(c);
      run_presses(phase_len[p]);
      drain_results();
    end

    while (indications_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d button samples over %0d settings and checked %0d result words.",
             ticks_taken, NumPhases + 1, words_checked);
    $display("Saw %0d short and %0d long presses; %0d mismatches.",
             short_seen, long_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/bpm_pkg.sv
design/bpm_if.sv
design/bpm_press_det.sv
design/bpm_mode_led.sv
design/button_press_mode_led_controller.sv
tb/tb_top.sv
